// ===== src/hmlp_pkg.sv =====
// Shared types and constants for the linear-probe name table.
`timescale 1ns / 1ps

package hmlp_pkg;

    localparam int KEY_W      = 64;
    localparam int ID_W       = 15;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 6;
    localparam int HASH_W     = 32;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [STATUS_W-1:0] ST_FOUND = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NEW   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // Request as handed from the front to the probe engine (key already cut).
    typedef struct packed {
        logic            op;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  tid;
    } req_t;

endpackage

// ===== src/hmlp_req_if.sv =====
// Request channel: opcode, name key and id with valid/ready.
`timescale 1ns / 1ps

interface hmlp_req_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [hmlp_pkg::KEY_W-1:0] key_bytes;
    logic [hmlp_pkg::ID_W-1:0]  task_id;

    modport source (output valid, output opcode, output key_bytes, output task_id,
                    input ready);
    modport sink   (input valid, input opcode, input key_bytes, input task_id,
                    output ready);
endinterface

// ===== src/hmlp_rsp_if.sv =====
// Response channel: status, slot and id with valid/ready.
`timescale 1ns / 1ps

interface hmlp_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [hmlp_pkg::STATUS_W-1:0]   status;
    logic [hmlp_pkg::SLOT_OUT_W-1:0] slot_index;
    logic [hmlp_pkg::ID_W-1:0]       id_out;

    modport source (output valid, output status, output slot_index, output id_out,
                    input ready);
    modport sink   (input valid, input status, input slot_index, input id_out,
                    output ready);
endinterface

// ===== src/hmlp_front.sv =====
// Front end: accepts requests, cuts the key, hashes it and reduces to a home slot.
`timescale 1ns / 1ps

module hmlp_front #(
    parameter int TABLE_SLOTS = 64,
    parameter int NAME_BYTES  = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    hmlp_req_if.sink                       req,
    input  logic                           clear_done,
    output hmlp_pkg::req_t                 push_req,
    output logic [$clog2(TABLE_SLOTS)-1:0] push_home,
    output logic                           push_valid,
    input  logic                           push_ready
);

    localparam int SLOT_W    = $clog2(TABLE_SLOTS);
    localparam int MOD_BITS  = 8;
    localparam int MOD_STEPS = hmlp_pkg::HASH_W / MOD_BITS;
    localparam int STEP_W    = $clog2(MOD_STEPS);
    localparam logic [SLOT_W:0] SLOTS_C = TABLE_SLOTS[SLOT_W:0];
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MOD_STEPS - 1);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_HASH = 2'd1;
    localparam logic [1:0] F_MOD  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]                      state_reg, state_next;
    hmlp_pkg::req_t                  req_reg, req_next;
    logic [3:0]                      len_reg, len_next;
    logic [3:0]                      idx_reg, idx_next;
    logic [hmlp_pkg::HASH_W-1:0]     hash_reg, hash_next;
    logic [SLOT_W-1:0]               rem_reg, rem_next;
    logic [STEP_W-1:0]               step_reg, step_next;

    logic [hmlp_pkg::KEY_W-1:0]      norm_key;
    logic [3:0]                      norm_len;
    logic [hmlp_pkg::HASH_W-1:0]     hash_step;
    logic [SLOT_W-1:0]               rem_step;
    logic                            accept;

    // Keep bytes up to the first zero byte, at most NAME_BYTES of them.
    always_comb
    begin
        logic keep;
        keep     = 1'b1;
        norm_key = '0;
        norm_len = '0;
        for (int n = 0; n < 8; n++)
        begin
            if (keep && (n < NAME_BYTES) && (req.key_bytes[n*8 +: 8] != 8'd0))
            begin
                norm_key[n*8 +: 8] = req.key_bytes[n*8 +: 8];
                norm_len           = 4'(n + 1);
            end
            else
            begin
                keep = 1'b0;
            end
        end
    end

    // h * 31 + byte, as (h << 5) - h
    assign hash_step = (hash_reg << 5) - hash_reg
                     + {24'd0, req_reg.key[{idx_reg[2:0], 3'b000} +: 8]};

    // Restoring reduction, MOD_BITS bits of the hash per cycle, msb first.
    always_comb
    begin
        logic [SLOT_W:0]   r2;
        logic [SLOT_W-1:0] r;
        r  = rem_reg;
        r2 = '0;
        for (int b = 0; b < MOD_BITS; b++)
        begin
            r2 = {r, hash_reg[hmlp_pkg::HASH_W-1-b]};
            if (r2 >= SLOTS_C)
            begin
                r2 = r2 - SLOTS_C;
            end
            r = r2[SLOT_W-1:0];
        end
        rem_step = r;
    end

    assign req.ready  = (state_reg == F_IDLE) && clear_done;
    assign accept     = req.valid && req.ready;
    assign push_valid = (state_reg == F_PUSH);
    assign push_req   = req_reg;
    assign push_home  = rem_reg;

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        hash_next  = hash_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    req_next.op  = req.opcode;
                    req_next.key = norm_key;
                    req_next.tid = req.task_id;
                    len_next     = norm_len;
                    idx_next     = '0;
                    hash_next    = '0;
                    rem_next     = '0;
                    step_next    = '0;
                    state_next   = (norm_len == 4'd0) ? F_MOD : F_HASH;
                end
            end
            F_HASH:
            begin
                hash_next = hash_step;
                idx_next  = idx_reg + 4'd1;
                if (idx_reg + 4'd1 == len_reg)
                begin
                    state_next = F_MOD;
                end
            end
            F_MOD:
            begin
                rem_next  = rem_step;
                hash_next = hash_reg << MOD_BITS;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        hash_reg <= hash_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
    end

endmodule

// ===== src/hmlp_queue.sv =====
// Two-entry queue between the hashing front and the probe engine.
`timescale 1ns / 1ps

module hmlp_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic [1:0]       count_reg, count_next;
    logic             wr_ptr_reg, rd_ptr_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

// ===== src/hmlp_back.sv =====
// Probe engine: slot memories, clearing pass, linear probe and result register.
`timescale 1ns / 1ps

module hmlp_back #(
    parameter int TABLE_SLOTS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  hmlp_pkg::req_t                 pop_req,
    input  logic [$clog2(TABLE_SLOTS)-1:0] pop_home,
    output logic                           clear_done,
    hmlp_rsp_if.source                     rsp
);

    localparam int SLOT_W     = $clog2(TABLE_SLOTS);
    localparam int SLOT_OUT_W = hmlp_pkg::SLOT_OUT_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    localparam logic [1:0] B_CLR  = 2'd0;
    localparam logic [1:0] B_IDLE = 2'd1;
    localparam logic [1:0] B_RD   = 2'd2;
    localparam logic [1:0] B_CHK  = 2'd3;

    logic                       valid_mem [TABLE_SLOTS];
    logic [hmlp_pkg::KEY_W-1:0] key_mem   [TABLE_SLOTS];
    logic [hmlp_pkg::ID_W-1:0]  id_mem    [TABLE_SLOTS];

    logic                       rd_valid_reg;
    logic [hmlp_pkg::KEY_W-1:0] rd_key_reg;
    logic [hmlp_pkg::ID_W-1:0]  rd_id_reg;

    logic [1:0]                      state_reg, state_next;
    logic [SLOT_W-1:0]               addr_reg, addr_next;
    logic [SLOT_W-1:0]               cnt_reg, cnt_next;
    logic [SLOT_W-1:0]               home_reg, home_next;
    hmlp_pkg::req_t                  cur_reg, cur_next;
    logic                            out_valid_reg, out_valid_next;
    logic [hmlp_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [SLOT_OUT_W-1:0]           slot_reg, slot_next;
    logic [hmlp_pkg::ID_W-1:0]       id_reg, id_next;

    logic out_free, hit, empty, finish, load;
    logic valid_we, valid_wd, key_we, id_we;

    assign clear_done = (state_reg != B_CLR);
    assign pop_ready  = (state_reg == B_IDLE);
    assign out_free   = !out_valid_reg || rsp.ready;
    assign empty      = !rd_valid_reg;
    assign hit        = rd_valid_reg && (rd_key_reg == cur_reg.key);
    assign finish     = empty || hit || (cnt_reg == LAST_SLOT);
    assign load       = (state_reg == B_CHK) && finish && out_free;

    assign valid_we = (state_reg == B_CLR)
                   || (load && empty && (cur_reg.op == hmlp_pkg::OP_INSERT));
    assign valid_wd = (state_reg != B_CLR);
    assign key_we   = load && empty && (cur_reg.op == hmlp_pkg::OP_INSERT);
    assign id_we    = load && (empty || hit) && (cur_reg.op == hmlp_pkg::OP_INSERT);

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.slot_index = slot_reg;
    assign rsp.id_out     = id_reg;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        cnt_next       = cnt_reg;
        home_next      = home_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        status_next    = status_reg;
        slot_next      = slot_reg;
        id_next        = id_reg;
        case (state_reg)
            B_CLR:
            begin
                addr_next = addr_reg + SLOT_W'(1);
                if (addr_reg == LAST_SLOT)
                begin
                    addr_next  = '0;
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    cur_next   = pop_req;
                    home_next  = pop_home;
                    addr_next  = pop_home;
                    cnt_next   = '0;
                    state_next = B_RD;
                end
            end
            B_RD:
            begin
                state_next = B_CHK;
            end
            B_CHK:
            begin
                if (!finish)
                begin
                    addr_next  = (addr_reg == LAST_SLOT) ? '0 : addr_reg + SLOT_W'(1);
                    cnt_next   = cnt_reg + SLOT_W'(1);
                    state_next = B_RD;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                    slot_next      = SLOT_OUT_W'(addr_reg);
                    id_next        = '0;
                    if (empty)
                    begin
                        status_next = (cur_reg.op == hmlp_pkg::OP_INSERT)
                                    ? hmlp_pkg::ST_NEW : hmlp_pkg::ST_MISS;
                    end
                    else if (hit)
                    begin
                        status_next = hmlp_pkg::ST_FOUND;
                        id_next     = (cur_reg.op == hmlp_pkg::OP_INSERT)
                                    ? cur_reg.tid : rd_id_reg;
                    end
                    else
                    begin
                        // every slot taken by other keys
                        status_next = hmlp_pkg::ST_FULL;
                        slot_next   = SLOT_OUT_W'(home_reg);
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLR;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        home_reg   <= home_next;
        cur_reg    <= cur_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        id_reg     <= id_next;
    end

    // Slot memories: one address, registered read.
    always_ff @(posedge clk)
    begin
        rd_valid_reg <= valid_mem[addr_reg];
        rd_key_reg   <= key_mem[addr_reg];
        rd_id_reg    <= id_mem[addr_reg];
        if (valid_we)
        begin
            valid_mem[addr_reg] <= valid_wd;
        end
        if (key_we)
        begin
            key_mem[addr_reg] <= cur_reg.key;
        end
        if (id_we)
        begin
            id_mem[addr_reg] <= cur_reg.tid;
        end
    end

    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != hmlp_pkg::ST_FOUND) |-> (id_reg == '0))
        else $error("id_out nonzero without a match");

    a_no_rsp_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLR) |-> !out_valid_reg)
        else $error("response during clearing pass");

    a_fill_empty_only: assert property (@(posedge clk) disable iff (!rst_n)
        key_we |-> (!rd_valid_reg && state_reg == B_CHK))
        else $error("key written over an occupied slot");

endmodule

// ===== src/hash_map_linear_probe.sv =====
// Top level of the linear-probe name-to-id table.
// Channels: req (opcode, key_bytes, task_id) in, rsp (status, slot_index,
// id_out) out, both valid/ready; an item moves when valid and ready are high.
// opcode lookup returns the stored id or not found; insert updates an existing
// key or fills the first empty slot; a full probe pass returns table full.
// After reset the block sweeps the valid bits with req.ready low; items are
// taken after that.
// Front: accept, the *31 hash at one name byte per cycle, an 8-bit restoring
// reduction mod TABLE_SLOTS, then a handoff into a two-entry queue, held while
// the queue is full; a new request is taken only after that handoff.
// Back: take the item, then per slot probed a registered memory read, then a
// compare; the result goes to an output register. It takes a new item only
// once the last result is loaded, so sustained throughput is set by the
// slower of the front and the back.
// A stalled rsp holds its item; the back finishes its probe only once the
// output register is free, and the queue lets the front keep hashing.
`timescale 1ns / 1ps

module hash_map_linear_probe #(
    parameter int TABLE_SLOTS = 64,
    parameter int NAME_BYTES  = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    hmlp_req_if.sink    req,
    hmlp_rsp_if.source  rsp
);

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int REQ_W   = $bits(hmlp_pkg::req_t);
    localparam int QUEUE_W = REQ_W + SLOT_W;

    hmlp_pkg::req_t    push_req, pop_req;
    logic [SLOT_W-1:0] push_home, pop_home;
    logic              push_valid, push_ready, pop_valid, pop_ready;
    logic              clear_done;
    logic [QUEUE_W-1:0] pop_data;

    hmlp_front #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .NAME_BYTES  (NAME_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .clear_done (clear_done),
        .push_req   (push_req),
        .push_home  (push_home),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    hmlp_queue #(
        .WIDTH (QUEUE_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_req, push_home}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_req  = pop_data[QUEUE_W-1:SLOT_W];
    assign pop_home = pop_data[SLOT_W-1:0];

    hmlp_back #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req),
        .pop_home   (pop_home),
        .clear_done (clear_done),
        .rsp        (rsp)
    );

endmodule
